### sv/kwc_pkg.sv
// Shared types, constants and helper functions of the keyword occurrence counter.
package kwc_pkg;

    // Parameter defaults
    localparam int MAX_WORD_DEF      = 100;
    localparam int KEYWORD_SLOTS_DEF = 6;
    localparam int TALLY_BITS_DEF    = 16;

    // Register map
    localparam int          NUM_KW_REGS = 6;
    localparam int          ADDR_W      = 6;
    localparam logic [2:0]  REG_IN_USE  = 3'd6;
    localparam logic [2:0]  IN_USE_RST  = 3'd6;

    // Keyword register reset values: auto, break, case, char, const, continue
    localparam logic [63:0] KW_RESET [NUM_KW_REGS] = '{
        64'd1869903201, 64'd461195539042, 64'd1702060387,
        64'd1918986339, 64'd500152823651, 64'd7310870969309884259
    };

    // Result kinds
    localparam logic [1:0] KIND_HIT    = 2'd0;
    localparam logic [1:0] KIND_REPORT = 2'd1;
    localparam logic [1:0] KIND_NONE   = 2'd2;

    // Token that walks down the cell chain
    typedef struct packed {
        logic        valid;
        logic        eot;      // end of text: cells report and clear
        logic        cmp;      // head holds a word worth comparing
        logic        hit;      // an earlier cell already matched
        logic [2:0]  hit_idx;
        logic [63:0] head;
    } t_tok;

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= 8'd65) && (b <= 8'd90)) || ((b >= 8'd97) && (b <= 8'd122));
    endfunction

    function automatic logic is_alnum(input logic [7:0] b);
        return is_letter(b) || ((b >= 8'd48) && (b <= 8'd57));
    endfunction

    // Cut a packed keyword at its first zero byte
    function automatic logic [63:0] trim_keyword(input logic [63:0] kw);
        logic [63:0] r;
        logic        stop;
        r    = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (kw[8*i +: 8] == 8'h00) stop = 1'b1;
            if (!stop) r[8*i +: 8] = kw[8*i +: 8];
        end
        return r;
    endfunction

endpackage

### sv/kwc_in_if.sv
// Text input channel: one byte or end-of-text marker per beat.
interface kwc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, text_byte, end_of_text, input ready);
    modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

### sv/kwc_out_if.sv
// Result channel: keyword hits, count reports and the none report.
interface kwc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  keyword_index;
    logic [15:0] occurrences;
    logic        last;

    modport source (output valid, kind, keyword_index, occurrences, last, input ready);
    modport sink   (input valid, kind, keyword_index, occurrences, last, output ready);
endinterface

### sv/kwc_scan.sv
// Word splitter: tracks words, issues a token when a word or the text ends.
module kwc_scan
    import kwc_pkg::*;
#(
    parameter int MAX_WORD = MAX_WORD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_eot,
    output t_tok       o_tok
);
    localparam int             LW   = $clog2(MAX_WORD);
    localparam logic [LW-1:0]  LIM  = LW'(MAX_WORD - 1);
    localparam logic [LW-1:0]  HEAD = LW'(8);

    logic          r_inside, n_inside;
    logic [LW-1:0] r_len, n_len;
    logic [63:0]   r_head, n_head;
    logic [LW-1:0] w_len1;
    logic [63:0]   w_head1;

    // Next word state and outgoing token
    always_comb begin
        n_inside = r_inside;
        n_len    = r_len;
        n_head   = r_head;
        o_tok    = '0;
        w_len1   = r_len + 1'b1;
        w_head1  = r_head;
        if (r_len < HEAD) begin
            w_head1 = r_head | (64'(i_byte) << {r_len[2:0], 3'b000});
        end
        if (i_accept) begin
            if (i_eot) begin
                o_tok.valid = 1'b1;
                o_tok.eot   = 1'b1;
                o_tok.cmp   = r_inside && (r_len <= HEAD);
                o_tok.head  = r_head;
                n_inside    = 1'b0;
                n_len       = '0;
                n_head      = '0;
            end else if (r_inside) begin
                if (is_alnum(i_byte)) begin
                    if (w_len1 >= LIM) begin
                        // long word: finished as soon as it reaches the limit
                        o_tok.valid = (w_len1 <= HEAD);
                        o_tok.cmp   = (w_len1 <= HEAD);
                        o_tok.head  = w_head1;
                        n_inside    = 1'b0;
                        n_len       = '0;
                        n_head      = '0;
                    end else begin
                        n_len  = w_len1;
                        n_head = w_head1;
                    end
                end else begin
                    o_tok.valid = (r_len <= HEAD);
                    o_tok.cmp   = (r_len <= HEAD);
                    o_tok.head  = r_head;
                    n_inside    = 1'b0;
                    n_len       = '0;
                    n_head      = '0;
                end
            end else if (is_letter(i_byte)) begin
                if (LIM <= LW'(1)) begin
                    o_tok.valid = 1'b1;
                    o_tok.cmp   = 1'b1;
                    o_tok.head  = 64'(i_byte);
                end else begin
                    n_inside = 1'b1;
                    n_len    = LW'(1);
                    n_head   = 64'(i_byte);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_len    <= '0;
            r_head   <= '0;
        end else begin
            r_inside <= n_inside;
            r_len    <= n_len;
            r_head   <= n_head;
        end
    end

endmodule

### sv/kwc_cell.sv
// One keyword cell: compares the passing word, keeps its tally, fills its report slot.
module kwc_cell
    import kwc_pkg::*;
#(
    parameter int IDX           = 0,
    parameter int KEYWORD_SLOTS = KEYWORD_SLOTS_DEF,
    parameter int TALLY_BITS    = TALLY_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  t_tok                                        i_tok,
    input  logic [TALLY_BITS-1:0]                       i_cnt,
    input  logic [KEYWORD_SLOTS-1:0][TALLY_BITS-1:0]    i_rep,
    input  logic [63:0]                                 i_keyword,
    input  logic                                        i_active,
    output t_tok                                        o_tok,
    output logic [TALLY_BITS-1:0]                       o_cnt,
    output logic [KEYWORD_SLOTS-1:0][TALLY_BITS-1:0]    o_rep
);
    logic [TALLY_BITS-1:0]                    r_tally, n_tally, w_inc;
    logic                                     w_match;
    t_tok                                     r_tok, n_tok;
    logic [TALLY_BITS-1:0]                    r_cnt, n_cnt;
    logic [KEYWORD_SLOTS-1:0][TALLY_BITS-1:0] r_rep, n_rep;

    // Compare, bump the saturating tally or clear it at text end, pass the token on
    always_comb begin
        w_match = i_tok.valid && i_tok.cmp && !i_tok.hit && i_active &&
                  (i_tok.head == trim_keyword(i_keyword));
        w_inc   = (&r_tally) ? r_tally : r_tally + 1'b1;
        n_tally = r_tally;
        if (i_en && i_tok.valid) begin
            if (i_tok.eot) begin
                n_tally = '0;
            end else if (w_match) begin
                n_tally = w_inc;
            end
        end
        n_tok = i_tok;
        n_cnt = i_cnt;
        if (w_match) begin
            n_tok.hit     = 1'b1;
            n_tok.hit_idx = 3'(IDX);
            n_cnt         = w_inc;
        end
        n_rep      = i_rep;
        n_rep[IDX] = w_match ? w_inc : r_tally;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally     <= '0;
            r_tok.valid <= 1'b0;
        end else begin
            r_tally <= n_tally;
            if (i_en) r_tok.valid <= n_tok.valid;
        end
        // Token payload
        if (i_en) begin
            r_tok.eot     <= n_tok.eot;
            r_tok.cmp     <= n_tok.cmp;
            r_tok.hit     <= n_tok.hit;
            r_tok.hit_idx <= n_tok.hit_idx;
            r_tok.head    <= n_tok.head;
            r_cnt         <= n_cnt;
            r_rep         <= n_rep;
        end
    end

    assign o_tok = r_tok;
    assign o_cnt = r_cnt;
    assign o_rep = r_rep;

endmodule

### sv/kwc_emit.sv
// Result stage: turns one finished token into its hit, report and none beats.
module kwc_emit
    import kwc_pkg::*;
#(
    parameter int KEYWORD_SLOTS = KEYWORD_SLOTS_DEF,
    parameter int TALLY_BITS    = TALLY_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  t_tok                                        i_tok,
    input  logic [TALLY_BITS-1:0]                       i_cnt,
    input  logic [KEYWORD_SLOTS-1:0][TALLY_BITS-1:0]    i_rep,
    input  logic                                        i_out_ready,
    output logic                                        o_take,
    output logic                                        o_valid,
    output logic [1:0]                                  o_kind,
    output logic [2:0]                                  o_index,
    output logic [15:0]                                 o_occ,
    output logic                                        o_last
);
    logic                                     r_busy, n_busy;
    logic                                     r_hit_pend, n_hit_pend;
    logic                                     r_none, n_none;
    logic [KEYWORD_SLOTS-1:0]                 r_mask, n_mask;
    logic [2:0]                               r_hit_idx;
    logic [TALLY_BITS-1:0]                    r_hit_cnt;
    logic [KEYWORD_SLOTS-1:0][TALLY_BITS-1:0] r_rep;
    logic [KEYWORD_SLOTS-1:0]                 w_rest, w_nz;
    logic [2:0]                               w_sel;
    logic [TALLY_BITS-1:0]                    w_sel_cnt;

    // Lowest pending report
    always_comb begin
        w_sel     = '0;
        w_sel_cnt = '0;
        for (int i = KEYWORD_SLOTS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_sel     = 3'(i);
                w_sel_cnt = r_rep[i];
            end
        end
        w_rest = r_mask & (r_mask - 1'b1);
        for (int i = 0; i < KEYWORD_SLOTS; i++) begin
            w_nz[i] = (i_rep[i] != '0);
        end
    end

    // Current beat: hit first, then reports in table order, else none
    always_comb begin
        o_valid = r_busy;
        if (r_hit_pend) begin
            o_kind  = KIND_HIT;
            o_index = r_hit_idx;
            o_occ   = 16'(r_hit_cnt);
            o_last  = (r_mask == '0) && !r_none;
        end else if (r_mask != '0) begin
            o_kind  = KIND_REPORT;
            o_index = w_sel;
            o_occ   = 16'(w_sel_cnt);
            o_last  = (w_rest == '0);
        end else begin
            o_kind  = KIND_NONE;
            o_index = '0;
            o_occ   = '0;
            o_last  = 1'b1;
        end
        o_take = !r_busy || (i_out_ready && o_last);
    end

    // Load a new token or retire the beat just taken
    always_comb begin
        n_busy     = r_busy;
        n_hit_pend = r_hit_pend;
        n_mask     = r_mask;
        n_none     = r_none;
        if (o_take) begin
            n_busy     = i_tok.valid && (i_tok.hit || i_tok.eot);
            n_hit_pend = i_tok.valid && i_tok.hit;
            n_mask     = (i_tok.valid && i_tok.eot) ? w_nz : '0;
            n_none     = i_tok.valid && i_tok.eot && !i_tok.hit && (w_nz == '0);
        end else if (r_busy && i_out_ready) begin
            if (r_hit_pend) begin
                n_hit_pend = 1'b0;
            end else begin
                n_mask = w_rest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_hit_pend <= 1'b0;
            r_mask     <= '0;
            r_none     <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_hit_pend <= n_hit_pend;
            r_mask     <= n_mask;
            r_none     <= n_none;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_hit_idx <= i_tok.hit_idx;
            r_hit_cnt <= i_cnt;
            r_rep     <= i_rep;
        end
    end

endmodule

### sv/keyword_occurrence_counter.sv
// Keyword occurrence counter: top level with register bank, cell chain and result stage.
//
// Text arrives on i_in, one byte per beat; a beat with end_of_text set closes the text.
// Words (a letter, then letters or digits) are split off by the front end and sent
// down a chain of KEYWORD_SLOTS cells, one per keyword, one cell per cycle while
// the chain moves. Each cell compares the word with its keyword and keeps that
// keyword's saturating tally. Results leave on o_out: a hit beat when a word matches;
// at end of text, a report beat for each nonzero tally in table order, or one none
// beat, with last on the final beat caused by that input.
// Throughput: one input beat per cycle while i_in.ready is high. An end-of-text beat
// gives up to KEYWORD_SLOTS+1 result beats, one per cycle while o_out.ready is high,
// and the chain waits meanwhile. A token is registered in each cell in turn, then
// in the result stage, which presents its result. A stalled receiver holds the
// result stage; the chain stops when a token reaches its end, and i_in.ready drops.
// Reset clears tallies, word state and all pending results, and loads the default
// keywords with all six in use. The user must write registers over APB only while the
// block is idle (not enforced by it); keyword i at byte address 8*i, in-use count at 48.
module keyword_occurrence_counter
    import kwc_pkg::*;
#(
    parameter int MAX_WORD      = MAX_WORD_DEF,
    parameter int KEYWORD_SLOTS = KEYWORD_SLOTS_DEF,
    parameter int TALLY_BITS    = TALLY_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    kwc_in_if.sink            i_in,
    kwc_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);
    typedef logic [KEYWORD_SLOTS-1:0][TALLY_BITS-1:0] t_rep;

    logic [63:0]           r_kw [NUM_KW_REGS];
    logic [2:0]            r_in_use;
    logic [2:0]            w_idx;
    logic                  w_en, w_accept, w_take;
    t_tok                  w_tok [KEYWORD_SLOTS+1];
    logic [TALLY_BITS-1:0] w_cnt [KEYWORD_SLOTS+1];
    t_rep                  w_rep [KEYWORD_SLOTS+1];

    // Register port
    assign pready = 1'b1;
    assign w_idx  = paddr[5:3];

    always_comb begin
        if (w_idx < REG_IN_USE) begin
            prdata = r_kw[w_idx];
        end else if (w_idx == REG_IN_USE) begin
            prdata = 64'(r_in_use);
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw     <= KW_RESET;
            r_in_use <= IN_USE_RST;
        end else if (psel && penable && pwrite) begin
            if (w_idx < REG_IN_USE) begin
                r_kw[w_idx] <= pwdata;
            end else if (w_idx == REG_IN_USE) begin
                r_in_use <= pwdata[2:0];
            end
        end
    end

    // Chain moves whenever its end token can be handed over
    assign w_en       = !w_tok[KEYWORD_SLOTS].valid || w_take;
    assign w_accept   = i_in.valid && w_en;
    assign i_in.ready = w_en;

    kwc_scan #(
        .MAX_WORD (MAX_WORD)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_in.text_byte),
        .i_eot    (i_in.end_of_text),
        .o_tok    (w_tok[0])
    );

    assign w_cnt[0] = '0;
    assign w_rep[0] = '0;

    // Keyword cells
    for (genvar g = 0; g < KEYWORD_SLOTS; g++) begin : g_cell
        kwc_cell #(
            .IDX           (g),
            .KEYWORD_SLOTS (KEYWORD_SLOTS),
            .TALLY_BITS    (TALLY_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_tok     (w_tok[g]),
            .i_cnt     (w_cnt[g]),
            .i_rep     (w_rep[g]),
            .i_keyword (r_kw[g]),
            .i_active  (3'(g) < r_in_use),
            .o_tok     (w_tok[g+1]),
            .o_cnt     (w_cnt[g+1]),
            .o_rep     (w_rep[g+1])
        );
    end

    kwc_emit #(
        .KEYWORD_SLOTS (KEYWORD_SLOTS),
        .TALLY_BITS    (TALLY_BITS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (w_tok[KEYWORD_SLOTS]),
        .i_cnt       (w_cnt[KEYWORD_SLOTS]),
        .i_rep       (w_rep[KEYWORD_SLOTS]),
        .i_out_ready (o_out.ready),
        .o_take      (w_take),
        .o_valid     (o_out.valid),
        .o_kind      (o_out.kind),
        .o_index     (o_out.keyword_index),
        .o_occ       (o_out.occurrences),
        .o_last      (o_out.last)
    );

    // Checks
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result beat right after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("input held off with no result pending");

    a_none_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == KIND_NONE)) |->
            (o_out.last && (o_out.keyword_index == 3'd0) && (o_out.occurrences == 16'd0)))
        else $error("none beat not a lone final beat");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.keyword_index < 3'(KEYWORD_SLOTS)))
        else $error("keyword index beyond the cells");

endmodule
